// ===== rtl/stx_pkg.sv =====
// ----------------------------------------------------------------------------
// stx_pkg
// Shared constants, codes and types for the STX/ETX frame transmitter.
// ----------------------------------------------------------------------------
package stx_pkg;

    localparam int MAX_BYTES = 32;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = CFG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] START_MARKER_RST = BYTE_W'(2);
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = BYTE_W'(3);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } stx_ram_req_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              last;
        logic              rejected;
    } stx_result_t;

endpackage

// ===== rtl/stx_buf_ram.sv =====
// ----------------------------------------------------------------------------
// stx_buf_ram
// Payload buffer: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module stx_buf_ram (
    input  logic                             clk,
    input  stx_pkg::stx_ram_req_t            req,
    output logic [stx_pkg::BYTE_W-1:0]       rdata
);

    logic [stx_pkg::BYTE_W-1:0] mem [stx_pkg::MAX_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// ===== rtl/stx_seq.sv =====
// ----------------------------------------------------------------------------
// stx_seq
// Frame sequencer: appends loads to the buffer, rejects loads into a full one, streams frames on send.
// ----------------------------------------------------------------------------
module stx_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          cmd,
    input  logic [stx_pkg::BYTE_W-1:0]    data_byte,
    input  logic [stx_pkg::BYTE_W-1:0]    start_marker,
    input  logic [stx_pkg::BYTE_W-1:0]    end_marker,
    input  logic [stx_pkg::BYTE_W-1:0]    ram_rdata,
    output stx_pkg::stx_ram_req_t         ram_req,
    output stx_pkg::stx_result_t          result,
    output logic                          busy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_COUNT = 6'b000100,
        S_DATA  = 6'b001000,
        S_XOR   = 6'b010000,
        S_END   = 6'b100000
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [stx_pkg::CNT_W-1:0]    count_reg;
    logic [stx_pkg::CNT_W-1:0]    count_next;
    logic [stx_pkg::BYTE_W-1:0]   xor_reg;
    logic [stx_pkg::BYTE_W-1:0]   xor_next;
    logic [stx_pkg::CNT_W-1:0]    idx_reg;
    logic [stx_pkg::CNT_W-1:0]    idx_next;
    logic [stx_pkg::CNT_W-1:0]    rd_idx;
    logic                         full;

    assign full   = (count_reg >= stx_pkg::CNT_W'(stx_pkg::MAX_BYTES));
    assign rd_idx = idx_reg + stx_pkg::CNT_W'(1);
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        idx_next   = idx_reg;
        ram_req    = '0;
        result     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == stx_pkg::CMD_SEND)
                    begin
                        state_next = S_START;
                    end
                    else if (full)
                    begin
                        result.valid    = 1'b1;
                        result.last     = 1'b1;
                        result.rejected = 1'b1;
                    end
                    else
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = count_reg[stx_pkg::ADDR_W-1:0];
                        ram_req.wdata = data_byte;
                        count_next    = count_reg + stx_pkg::CNT_W'(1);
                        xor_next      = xor_reg ^ data_byte;
                    end
                end
            end
            S_START:
            begin
                result.valid   = 1'b1;
                result.tx_byte = start_marker;
                ram_req.re     = 1'b1;
                ram_req.raddr  = '0;
                idx_next       = '0;
                state_next     = S_COUNT;
            end
            S_COUNT:
            begin
                result.valid   = 1'b1;
                result.tx_byte = stx_pkg::BYTE_W'(count_reg);
                state_next     = (count_reg == '0) ? S_XOR : S_DATA;
            end
            S_DATA:
            begin
                result.valid   = 1'b1;
                result.tx_byte = ram_rdata;
                ram_req.re     = (rd_idx < count_reg);
                ram_req.raddr  = rd_idx[stx_pkg::ADDR_W-1:0];
                idx_next       = rd_idx;
                if (rd_idx == count_reg)
                begin
                    state_next = S_XOR;
                end
            end
            S_XOR:
            begin
                result.valid   = 1'b1;
                result.tx_byte = xor_reg;
                state_next     = S_END;
            end
            S_END:
            begin
                result.valid   = 1'b1;
                result.tx_byte = end_marker;
                result.last    = 1'b1;
                count_next     = '0;
                xor_next       = '0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            xor_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== rtl/stx_length_xor_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// stx_length_xor_frame_transmitter
// STX/ETX framer with byte count and XOR checksum over a buffered payload.
// ----------------------------------------------------------------------------
// Command channel: a command transfers on a clock edge with start high and
// busy low. cmd selects load (append data_byte) or send (emit the frame).
// A load gives no result and leaves busy low, so loads can follow every
// cycle. A load into a full buffer gives one result, in the cycle after
// the transfer, with rejected and frame_last set and tx_byte zero.
// A send raises busy through the start, count, data, XOR and end states;
// the frame leaves the output registers one byte per cycle with valid
// high: start marker, byte count, payload bytes in load order, XOR
// checksum, end marker (with frame_last). The buffer's single read port
// supplies one payload byte per cycle. The end marker shows in the first
// cycle in which busy is low again, so the next command may transfer there.
// Results cannot be held off; each is valid for exactly one cycle.
// Register writes (cfg_we, cfg_index, cfg_data) take effect at once;
// index 0 is the start marker, index 1 the end marker.
// Reset returns the markers to 2 and 3 and empties the payload.
// ----------------------------------------------------------------------------
module stx_length_xor_frame_transmitter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic [stx_pkg::BYTE_W-1:0]         data_byte,
    output logic                               valid,
    output logic [stx_pkg::BYTE_W-1:0]         tx_byte,
    output logic                               frame_last,
    output logic                               rejected,
    input  logic                               cfg_we,
    input  logic [stx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stx_pkg::BYTE_W-1:0]         cfg_data
);

    logic [stx_pkg::BYTE_W-1:0] start_marker_reg;
    logic [stx_pkg::BYTE_W-1:0] end_marker_reg;
    logic [stx_pkg::BYTE_W-1:0] ram_rdata;
    stx_pkg::stx_ram_req_t      ram_req;
    stx_pkg::stx_result_t       result;
    logic                       valid_reg;
    logic [stx_pkg::BYTE_W-1:0] tx_byte_reg;
    logic                       last_reg;
    logic                       rejected_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= stx_pkg::START_MARKER_RST;
            end_marker_reg   <= stx_pkg::END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stx_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data;
                stx_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    stx_buf_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    stx_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .ram_rdata    (ram_rdata),
        .ram_req      (ram_req),
        .result       (result),
        .busy         (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_byte_reg  <= result.tx_byte;
        last_reg     <= result.last;
        rejected_reg <= result.rejected;
    end

    assign valid      = valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign frame_last = valid_reg & last_reg;
    assign rejected   = valid_reg & rejected_reg;

endmodule

// ===== rtl/stx_checker.sv =====
// ----------------------------------------------------------------------------
// stx_checker
// Port-level checks for the frame transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module stx_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          cmd,
    input  logic                          valid,
    input  logic [stx_pkg::BYTE_W-1:0]    tx_byte,
    input  logic                          frame_last,
    input  logic                          rejected
);

    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && rejected) |-> (frame_last && tx_byte == '0))
        else $error("rejection result malformed");

    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == stx_pkg::CMD_SEND) |=> busy)
        else $error("send transfer did not raise busy");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && frame_last && !rejected) |-> !busy)
        else $error("end marker while still busy");

    a_fall_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (valid && frame_last && !rejected))
        else $error("frame ended without end marker");

    a_no_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !(valid && rejected))
        else $error("rejection during a frame");

endmodule

bind stx_length_xor_frame_transmitter stx_checker u_stx_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .valid      (valid),
    .tx_byte    (tx_byte),
    .frame_last (frame_last),
    .rejected   (rejected)
);
